FILE: rtl/spq_pkg.sv
// Shared types and constants for the stable priority queue.
`timescale 1ns / 1ps

package spq_pkg;

   // Request opcodes
   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_DEQUEUE = 1'b1;

   // Result status codes
   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   localparam int DATA_W = 32;
   localparam int PRIO_W = 16;
   localparam int FILL_W = 5;

   // Data returned by a dequeue on an empty queue
   localparam logic signed [DATA_W-1:0] DATA_EMPTY = -32'sd1;

   typedef struct packed {
      logic                     req_type;
      logic signed [DATA_W-1:0] item_data;
      logic [PRIO_W-1:0]        item_priority;
   } req_item_type;

   typedef struct packed {
      logic [1:0]               status;
      logic signed [DATA_W-1:0] out_data;
      logic [FILL_W-1:0]        fill_count;
   } rsp_item_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;   // capture the request item
      logic exec;   // update the entry cells and the result register
   } dp_cmd_type;

endpackage

FILE: rtl/spq_ctrl.sv
// Controller state machine for the stable priority queue.
`timescale 1ns / 1ps

module spq_ctrl
   import spq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   output logic       rsp_valid,
   output dp_cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_RESP = 3'b100
   } state_type;

   state_type state_ff, state_in;

   // A new item may be taken while the previous result is on the strobe
   assign busy      = (state_ff == S_EXEC);
   assign rsp_valid = (state_ff == S_RESP);
   assign cmd.load  = start && !busy;
   assign cmd.exec  = (state_ff == S_EXEC);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            state_in = start ? S_EXEC : S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Result strobe lasts one cycle
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // An accepted item is worked on next cycle, with no result shown
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (cmd.exec && !rsp_valid))
      else $error("accepted item not executed");

endmodule

FILE: rtl/spq_datapath.sv
// Entry cells, fill count and result register of the stable priority queue.
`timescale 1ns / 1ps

module spq_datapath
   import spq_pkg::*;
#(
   parameter int DEPTH = 16
)
(
   input  logic         clock,
   input  logic         reset,
   input  dp_cmd_type   cmd,
   input  req_item_type req_item,
   output rsp_item_type rsp_item
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] COUNT_FULL = CW'(DEPTH);

   req_item_type             req_ff;
   rsp_item_type             rsp_ff, rsp_in;
   logic signed [DATA_W-1:0] data_ff [DEPTH];
   logic signed [DATA_W-1:0] data_in [DEPTH];
   logic [PRIO_W-1:0]        prio_ff [DEPTH];
   logic [PRIO_W-1:0]        prio_in [DEPTH];
   logic [CW-1:0]            count_ff, count_in;

   logic [DEPTH-1:0] ins;      // cell takes the new entry or its left neighbor
   logic             full, empty, is_deq, cells_we;

   assign full   = (count_ff == COUNT_FULL);
   assign empty  = (count_ff == '0);
   assign is_deq = (req_ff.req_type == OP_DEQUEUE);

   // Per-cell insert flag: cell is free or holds a strictly larger priority
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         ins[i] = (CW'(i) >= count_ff) || (prio_ff[i] > req_ff.item_priority);
      end
   end

   // Next cell contents: shift right behind the insert point, or shift left on dequeue
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         data_in[i] = data_ff[i];
         prio_in[i] = prio_ff[i];
         if (is_deq) begin
            if (i < DEPTH - 1) begin
               data_in[i] = data_ff[(i < DEPTH - 1) ? i + 1 : i];
               prio_in[i] = prio_ff[(i < DEPTH - 1) ? i + 1 : i];
            end
         end else if (ins[i]) begin
            if (i > 0 && ins[(i > 0) ? i - 1 : 0]) begin
               data_in[i] = data_ff[(i > 0) ? i - 1 : 0];
               prio_in[i] = prio_ff[(i > 0) ? i - 1 : 0];
            end else begin
               data_in[i] = req_ff.item_data;
               prio_in[i] = req_ff.item_priority;
            end
         end
      end
   end

   // Result and count for the item in hand
   always_comb begin
      count_in = count_ff;
      cells_we = 1'b0;
      rsp_in   = rsp_ff;
      if (is_deq) begin
         if (empty) begin
            rsp_in.status   = ST_EMPTY;
            rsp_in.out_data = DATA_EMPTY;
         end else begin
            rsp_in.status   = ST_DONE;
            rsp_in.out_data = data_ff[0];
            count_in        = count_ff - CW'(1);
            cells_we        = 1'b1;
         end
      end else begin
         rsp_in.out_data = '0;
         if (full) begin
            rsp_in.status = ST_FULL;
         end else begin
            rsp_in.status = ST_DONE;
            count_in      = count_ff + CW'(1);
            cells_we      = 1'b1;
         end
      end
      rsp_in.fill_count = FILL_W'(count_in);
   end

   // Control state: fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.exec) begin
         count_ff <= count_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_item;
      end
      if (cmd.exec) begin
         rsp_ff <= rsp_in;
      end
      if (cmd.exec && cells_we) begin
         for (int i = 0; i < DEPTH; i++) begin
            data_ff[i] <= data_in[i];
            prio_ff[i] <= prio_in[i];
         end
      end
   end

   assign rsp_item = rsp_ff;

   // Count never passes the depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_FULL)
      else $error("fill count beyond depth");

   // Enqueue into a queue with room grows it by one
   a_enq_grows: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && !is_deq && !full) |=> (count_ff == CW'($past(count_ff) + CW'(1))))
      else $error("enqueue did not add an entry");

   // Dequeue on an empty queue reports empty with all-ones data
   a_deq_empty: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && is_deq && empty) |=>
         (rsp_ff.status == ST_EMPTY && rsp_ff.out_data == DATA_EMPTY && empty))
      else $error("empty dequeue result wrong");

endmodule

FILE: rtl/stable_priority_queue.sv
// Top level of the stable priority queue: controller plus entry datapath.
`timescale 1ns / 1ps
//
// Bounded priority queue of DEPTH entries kept sorted by priority; a smaller
// priority leaves first and equal priorities leave in arrival order.
// Request channel: an item (req_item) is taken at a rising edge with start
// high and busy low. req_type selects enqueue or dequeue of the head.
// Result channel: one result per item, on rsp_item for exactly one cycle
// while rsp_valid is high; the receiver cannot hold it off.
// The accepting edge moves the controller to S_EXEC, which writes the result
// register; the result strobe is high in the next state, S_RESP.
// Busy is high only in S_EXEC, the cycle in which the entry cells compare
// against the new priority and shift as one row; no item is taken then.
// A new item may be started in the cycle its predecessor's result shows.
// Status: done, empty (dequeue with no entries, data all ones) or full
// (enqueue dropped). fill_count gives the entries held after the item.
// Reset (synchronous, active high) empties the queue; no clearing pass.
//
module stable_priority_queue
   import spq_pkg::*;
#(
   parameter int DEPTH = 16
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_item_type req_item,
   output logic         rsp_valid,
   output rsp_item_type rsp_item
);

   dp_cmd_type cmd;

   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   spq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_item (req_item),
      .rsp_item (rsp_item)
   );

endmodule
